@@ src/largest_empty_square_scan_top_defines.svh @@
// Assertion macros shared by the largest empty square scan checker.
`ifndef LARGEST_EMPTY_SQUARE_SCAN_TOP_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_SCAN_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LESQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LESQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/lesq_pkg.sv @@
// Types and constants shared by the largest empty square scan modules.
`timescale 1ns / 1ps

package lesq_pkg;

   localparam int CHAR_W    = 8;
   localparam int DIM_W     = 11;
   localparam int SIZE_W    = 11;
   localparam int POS_W     = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE_CHAR = 2'd2;

   localparam logic [CHAR_W-1:0] OBSTACLE_RESET = 8'd111;

   typedef struct packed {
      logic obstacle;
      logic border;
      logic last_grid;
   } cell_flags_type;

   localparam int FLAGS_W = $bits(cell_flags_type);

endpackage

@@ src/lesq_fifo.sv @@
// Small synchronous FIFO used between the scan stages and at the result side.
`timescale 1ns / 1ps

module lesq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = storage_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         storage_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ src/lesq_front.sv @@
// Front stage: takes grid cells, tracks the scan position and classifies each cell.
`timescale 1ns / 1ps

module lesq_front #(
   parameter int ROW_W = 10,
   parameter int COL_W = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_push,
   input  logic [lesq_pkg::CHAR_W-1:0] in_char,
   output logic                        in_full,
   input  logic [ROW_W-1:0]            rows_last,
   input  logic [COL_W-1:0]            cols_last,
   input  logic [lesq_pkg::CHAR_W-1:0] obstacle_char,
   output logic                        q_push,
   output lesq_pkg::cell_flags_type    q_flags,
   output logic [ROW_W-1:0]            q_row,
   output logic [COL_W-1:0]            q_col,
   input  logic                        q_full
);

   import lesq_pkg::*;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             accept, last_col, last_row;

   assign in_full = q_full;
   assign accept  = in_push & ~q_full;
   assign q_push  = accept;
   assign q_row   = row_ff;
   assign q_col   = col_ff;

   always_comb begin
      last_col          = (col_ff >= cols_last);
      last_row          = (row_ff >= rows_last);
      q_flags.obstacle  = (in_char == obstacle_char);
      q_flags.border    = (row_ff == '0) | (col_ff == '0);
      q_flags.last_grid = last_col & last_row;
      row_in            = row_ff;
      col_in            = col_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

@@ src/lesq_back.sv @@
// Back stage: line store, square size recurrence and best square tracking.
`timescale 1ns / 1ps

module lesq_back #(
   parameter int MAX_COLS = 1024,
   parameter int ROW_W    = 10,
   parameter int COL_W    = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  lesq_pkg::cell_flags_type    q_flags,
   input  logic [ROW_W-1:0]            q_row,
   input  logic [COL_W-1:0]            q_col,
   output logic                        q_pop,
   input  logic                        r_full,
   output logic                        r_push,
   output logic [lesq_pkg::POS_W-1:0]  r_row,
   output logic [lesq_pkg::POS_W-1:0]  r_col,
   output logic [lesq_pkg::SIZE_W-1:0] r_size
);

   import lesq_pkg::*;

   logic [SIZE_W-1:0] line_mem [MAX_COLS];

   logic              a_valid_ff, a_valid_in;
   cell_flags_type    a_flags_ff;
   logic [ROW_W-1:0]  a_row_ff;
   logic [COL_W-1:0]  a_col_ff;
   logic [SIZE_W-1:0] up_ff;

   logic [SIZE_W-1:0] left_ff, left_in;
   logic [SIZE_W-1:0] diag_ff, diag_in;
   logic [SIZE_W-1:0] best_size_ff, best_size_in;
   logic [ROW_W-1:0]  best_row_ff, best_row_in;
   logic [COL_W-1:0]  best_col_ff, best_col_in;

   logic              commit, load, better;
   logic [SIZE_W-1:0] min_ul, min_all, size;

   assign commit = a_valid_ff & (~a_flags_ff.last_grid | ~r_full);
   assign load   = ~q_empty & (~a_valid_ff | commit);
   assign q_pop  = load;
   assign r_push = commit & a_flags_ff.last_grid;
   assign r_row  = POS_W'(better ? a_row_ff : best_row_ff);
   assign r_col  = POS_W'(better ? a_col_ff : best_col_ff);
   assign r_size = better ? size : best_size_ff;

   always_comb begin
      min_ul  = (up_ff < left_ff) ? up_ff : left_ff;
      min_all = (diag_ff < min_ul) ? diag_ff : min_ul;
      if (a_flags_ff.obstacle) begin
         size = '0;
      end else if (a_flags_ff.border) begin
         size = SIZE_W'(1);
      end else begin
         size = min_all + 1'b1;
      end
      better = (size > best_size_ff);
   end

   always_comb begin
      a_valid_in   = load ? 1'b1 : (commit ? 1'b0 : a_valid_ff);
      left_in      = left_ff;
      diag_in      = diag_ff;
      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      if (commit) begin
         if (a_flags_ff.last_grid) begin
            left_in      = '0;
            diag_in      = '0;
            best_size_in = '0;
            best_row_in  = '0;
            best_col_in  = '0;
         end else begin
            left_in = size;
            diag_in = up_ff;
            if (better) begin
               best_size_in = size;
               best_row_in  = a_row_ff;
               best_col_in  = a_col_ff;
            end
         end
      end
   end

   // The same column can be written and read in one cycle only when a row is one
   // cell wide; the fresh size is forwarded in that case.
   always_ff @(posedge clock) begin
      if (commit) begin
         line_mem[a_col_ff] <= size;
      end
      if (load) begin
         up_ff <= (commit && (a_col_ff == q_col)) ? size : line_mem[q_col];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_flags_ff <= q_flags;
         a_row_ff   <= q_row;
         a_col_ff   <= q_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         left_ff      <= '0;
         diag_ff      <= '0;
         best_size_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         left_ff      <= left_in;
         diag_ff      <= diag_in;
         best_size_ff <= best_size_in;
         best_row_ff  <= best_row_in;
         best_col_ff  <= best_col_in;
      end
   end

endmodule

@@ src/largest_empty_square_scan_top.sv @@
// Top level of the largest empty square scan: configuration, front, queue and back.
`timescale 1ns / 1ps

// The block takes grid cells in row-major order, one request per clock while not
// full, and after the last cell of each grid it offers one result: the largest
// obstacle-free square (size 0 at row 0, column 0 if there is none), the first one
// in scan order on a tie. It sustains one cell per clock unless stalled; the last
// cell passes the cell queue and line store read register before its result is
// pushed. A two-entry queue separates cell classification from the size update,
// and a two-entry result queue lets requests keep flowing while a result waits.
// Write the grid size and obstacle character only while no grid is in progress.
module largest_empty_square_scan_top #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic [lesq_pkg::CHAR_W-1:0]    req_cell_char,
   output logic                           req_full,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [lesq_pkg::POS_W-1:0]     rsp_best_row,
   output logic [lesq_pkg::POS_W-1:0]     rsp_best_col,
   output logic [lesq_pkg::SIZE_W-1:0]    rsp_best_size,
   input  logic                           csr_wr_en,
   input  logic [lesq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lesq_pkg::DIM_W-1:0]     csr_wdata
);

   import lesq_pkg::*;

   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int MID_W = FLAGS_W + ROW_W + COL_W;
   localparam int RSP_W = 2 * POS_W + SIZE_W;

   logic [ROW_W-1:0]  rows_last_ff, rows_last_in;
   logic [COL_W-1:0]  cols_last_ff, cols_last_in;
   logic [CHAR_W-1:0] obstacle_ff, obstacle_in;
   logic [ROW_W-1:0]  rows_wr_last;
   logic [COL_W-1:0]  cols_wr_last;

   logic              f_push, mid_full, mid_empty, mid_pop;
   cell_flags_type    f_flags, b_flags;
   logic [ROW_W-1:0]  f_row, b_row;
   logic [COL_W-1:0]  f_col, b_col;
   logic [MID_W-1:0]  mid_rd_data;

   logic              r_push, r_full;
   logic [POS_W-1:0]  r_row, r_col;
   logic [SIZE_W-1:0] r_size;

   always_comb begin
      if (csr_wdata == '0) begin
         rows_wr_last = '0;
      end else if (32'(csr_wdata) > MAX_ROWS) begin
         rows_wr_last = ROW_W'(MAX_ROWS - 1);
      end else begin
         rows_wr_last = ROW_W'(csr_wdata - 1'b1);
      end
      if (csr_wdata == '0) begin
         cols_wr_last = '0;
      end else if (32'(csr_wdata) > MAX_COLS) begin
         cols_wr_last = COL_W'(MAX_COLS - 1);
      end else begin
         cols_wr_last = COL_W'(csr_wdata - 1'b1);
      end
      rows_last_in = rows_last_ff;
      cols_last_in = cols_last_ff;
      obstacle_in  = obstacle_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_ROWS:     rows_last_in = rows_wr_last;
            CSR_GRID_COLS:     cols_last_in = cols_wr_last;
            CSR_OBSTACLE_CHAR: obstacle_in  = csr_wdata[CHAR_W-1:0];
            default:           obstacle_in  = obstacle_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_last_ff <= '0;
         cols_last_ff <= '0;
         obstacle_ff  <= OBSTACLE_RESET;
      end else begin
         rows_last_ff <= rows_last_in;
         cols_last_ff <= cols_last_in;
         obstacle_ff  <= obstacle_in;
      end
   end

   lesq_front #(
      .ROW_W (ROW_W),
      .COL_W (COL_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_push       (req_push),
      .in_char       (req_cell_char),
      .in_full       (req_full),
      .rows_last     (rows_last_ff),
      .cols_last     (cols_last_ff),
      .obstacle_char (obstacle_ff),
      .q_push        (f_push),
      .q_flags       (f_flags),
      .q_row         (f_row),
      .q_col         (f_col),
      .q_full        (mid_full)
   );

   lesq_fifo #(
      .WIDTH (MID_W),
      .DEPTH (2)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_flags, f_row, f_col}),
      .full      (mid_full),
      .pop       (mid_pop),
      .empty     (mid_empty),
      .pop_data  (mid_rd_data)
   );

   assign {b_flags, b_row, b_col} = mid_rd_data;

   lesq_back #(
      .MAX_COLS (MAX_COLS),
      .ROW_W    (ROW_W),
      .COL_W    (COL_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (mid_empty),
      .q_flags (b_flags),
      .q_row   (b_row),
      .q_col   (b_col),
      .q_pop   (mid_pop),
      .r_full  (r_full),
      .r_push  (r_push),
      .r_row   (r_row),
      .r_col   (r_col),
      .r_size  (r_size)
   );

   lesq_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (r_push),
      .push_data ({r_row, r_col, r_size}),
      .full      (r_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  ({rsp_best_row, rsp_best_col, rsp_best_size})
   );

endmodule

@@ src/lesq_checker.sv @@
// Port-level checker for the largest empty square scan, bound to the top level.
`timescale 1ns / 1ps
`include "largest_empty_square_scan_top_defines.svh"

module lesq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_full,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic [lesq_pkg::POS_W-1:0]  rsp_best_row,
   input logic [lesq_pkg::POS_W-1:0]  rsp_best_col,
   input logic [lesq_pkg::SIZE_W-1:0] rsp_best_size
);

   `LESQ_ASSERT_SAME(a_reset_clears_queues, clock, reset, $past(reset),
      rsp_empty && !req_full, "queues not cleared by reset")

   `LESQ_ASSERT_SAME(a_empty_grid_at_origin, clock, reset,
      !rsp_empty && (rsp_best_size == '0),
      (rsp_best_row == '0) && (rsp_best_col == '0), "size zero away from origin")

   `LESQ_ASSERT_NEXT(a_result_holds, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_best_row) && $stable(rsp_best_col) &&
      $stable(rsp_best_size), "waiting result changed")

endmodule

bind largest_empty_square_scan_top lesq_checker u_checker (.*);
